// ===== rtl/core/tfz_pkg.sv =====
// Shared types, constants and helpers for the thermal fan zone controller.
`default_nettype none

package tfz_pkg;

  localparam int TEMP_W_DEF = 8;
  localparam int CNT_W_DEF  = 6;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SPD_W      = 2;

  typedef logic [SPD_W-1:0] spd_t;

  localparam spd_t SPD_OFF  = 2'd0;
  localparam spd_t SPD_LOW  = 2'd1;
  localparam spd_t SPD_HIGH = 2'd2;
  localparam spd_t SPD_NONE = 2'd3;

  localparam logic [1:0] TGT_BOTH = 2'd2;

  localparam logic [1:0] SRC_CPU = 2'd0;
  localparam logic [1:0] SRC_MAX = 2'd1;
  localparam logic [1:0] SRC_SEP = 2'd2;

  localparam int MODE_BOUNDARY = 0;
  localparam int MODE_MON      = 3;
  localparam int MODE_RBOFF    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD   = 3'd0,
    CFG_READBACK_PERIOD = 3'd1,
    CFG_JUMP_HOLD       = 3'd2,
    CFG_JUMP_DELTA      = 3'd3,
    CFG_ZONE_THRESH     = 3'd4,
    CFG_ZONE_SPEEDS     = 3'd5,
    CFG_MODE_BITS       = 3'd6,
    CFG_FAN_SELECT      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [5:0]  sample_period;
    logic [5:0]  readback_period;
    logic [5:0]  jump_hold;
    logic [7:0]  jump_delta;
    logic [23:0] thresholds;
    logic [5:0]  speeds;
    logic [4:0]  mode;
    logic [2:0]  fan_sel;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sample_period:   6'd10,
    readback_period: 6'd10,
    jump_hold:       6'd20,
    jump_delta:      8'd5,
    thresholds:      24'd5258285,
    speeds:          6'd36,
    mode:            5'd2,
    fan_sel:         3'd6
  };

  typedef struct packed {
    logic active;
    logic do_rb;
    logic do_smp;
    logic prime;
    logic mon;
    logic boundary;
    logic rb_off;
    logic sep;
    logic fan;
    logic chan_id;
    logic last;
  } chan_ctl_t;

  typedef struct packed {
    spd_t cmd;
    spd_t obs;
    spd_t ls;
  } spd_state_t;

  localparam spd_state_t SPD_STATE_RESET = '{cmd: SPD_OFF, obs: SPD_OFF, ls: SPD_NONE};

  typedef struct packed {
    logic       channel;
    logic       cmd_valid;
    logic [1:0] cmd_target;
    spd_t       cmd_speed;
    logic       holdoff_active;
    logic       last;
  } res_t;

  function automatic spd_t clamp_spd(input logic [1:0] s);
    return (s == SPD_NONE) ? SPD_HIGH : spd_t'(s);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/thermal_fan_zone_controller_core.sv =====
// Thermal fan zone controller: one tick per input beat, one result beat per active channel.
//
// Input channel in_*: one tick with CPU and GPU temperatures and the two observed
// fan speeds, taken when in_valid and in_ready are both high.
// Result channel out_*: one beat per active channel (channel 0, then channel 1
// in separate source mode), out_last on the final beat of the tick; ticks
// between samples and readbacks give no beat at all.
// Configuration: cfg_we writes cfg_data into register cfg_index on the edge.
// Pipeline: an accepted tick is registered in the input register and evaluated from
// there once the result buffer is free; its result beats are registered in that buffer.
// Throughput: one tick per cycle while out_ready is high and a tick gives at most one
// result; a tick that gives two holds off the next tick until its first beat has left,
// as the single result port sends one beat at a time. A tick with no result pushes none.
// Reset: configuration takes its defaults, all temperatures, holdoffs and
// countdowns clear, no speed is marked as sent, the first sample primes.
// Stall: the two-entry result buffer holds its beats while out_ready is low;
// the input register then holds one tick and in_ready drops.
`default_nettype none

module thermal_fan_zone_controller_core import tfz_pkg::*; #(
  parameter int TEMP_WIDTH    = TEMP_W_DEF,
  parameter int COUNTER_WIDTH = CNT_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TEMP_WIDTH-1:0] in_cpu_temp,
  input  logic [TEMP_WIDTH-1:0] in_gpu_temp,
  input  logic [1:0]            in_right_fan_speed,
  input  logic [1:0]            in_left_fan_speed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_channel,
  output logic                  out_cmd_valid,
  output logic [1:0]            out_cmd_target,
  output logic [1:0]            out_cmd_speed,
  output logic                  out_holdoff_active,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                     cfg_r;
  logic                     in_vld_r;
  logic                     in_vld_nxt;
  logic [TEMP_WIDTH-1:0]    cpu_r;
  logic [TEMP_WIDTH-1:0]    gpu_r;
  logic [1:0]               right_r;
  logic [1:0]               left_r;

  logic [COUNTER_WIDTH-1:0] sc_r;
  logic [COUNTER_WIDTH-1:0] sc_nxt;
  logic [COUNTER_WIDTH-1:0] sc_dec;
  logic [COUNTER_WIDTH-1:0] rc_r;
  logic [COUNTER_WIDTH-1:0] rc_nxt;
  logic [COUNTER_WIDTH-1:0] rc_dec;
  logic                     primed_r;
  logic                     primed_nxt;

  logic [TEMP_WIDTH-1:0]    temp_r   [2];
  logic [TEMP_WIDTH-1:0]    temp_nxt [2];
  logic [TEMP_WIDTH-1:0]    prev_r   [2];
  logic [TEMP_WIDTH-1:0]    prev_nxt [2];
  spd_state_t               spd_r    [2];
  spd_state_t               spd_nxt  [2];
  logic [COUNTER_WIDTH-1:0] ho_r     [2];
  logic [COUNTER_WIDTH-1:0] ho_nxt   [2];
  logic [TEMP_WIDTH-1:0]    meas     [2];
  chan_ctl_t                ctl      [2];
  res_t                     res      [2];

  logic       accept;
  logic       adv;
  logic       free;
  logic       mon;
  logic       sep;
  logic       skip;
  logic       do_rb;
  logic       do_smp;
  logic [1:0] src;
  spd_t       right_c;
  spd_t       left_c;
  res_t       out_res;

  assign accept   = in_valid && in_ready;
  assign adv      = in_vld_r && free;
  assign in_ready = !in_vld_r || free;

  assign src     = cfg_r.mode[2:1];
  assign sep     = (src == SRC_SEP);
  assign mon     = cfg_r.mode[MODE_MON];
  assign right_c = clamp_spd(right_r);
  assign left_c  = clamp_spd(left_r);

  assign sc_dec = (sc_r != '0) ? sc_r - 1'b1 : sc_r;
  assign rc_dec = (rc_r != '0) ? rc_r - 1'b1 : rc_r;
  assign skip   = (sc_dec != '0) && ((rc_dec != '0) || mon);
  assign do_rb  = !skip && (rc_dec == '0);
  assign do_smp = !skip && (sc_dec == '0);

  assign meas[0] = (src == SRC_MAX && gpu_r > cpu_r) ? gpu_r : cpu_r;
  assign meas[1] = gpu_r;

  always_comb begin
    rc_nxt = rc_dec;
    if (do_rb) begin
      rc_nxt = COUNTER_WIDTH'(cfg_r.mode[MODE_RBOFF] ? cfg_r.sample_period
                                                     : cfg_r.readback_period);
    end
    sc_nxt     = do_smp ? COUNTER_WIDTH'(cfg_r.sample_period) : sc_dec;
    primed_nxt = primed_r || do_smp;
    in_vld_nxt = accept ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      ctl[c].do_rb    = do_rb;
      ctl[c].do_smp   = do_smp;
      ctl[c].prime    = do_smp && !primed_r;
      ctl[c].mon      = mon;
      ctl[c].boundary = cfg_r.mode[MODE_BOUNDARY];
      ctl[c].rb_off   = cfg_r.mode[MODE_RBOFF];
      ctl[c].sep      = sep;
    end
    ctl[0].active  = !skip;
    ctl[0].fan     = sep ? cfg_r.fan_sel[0] : cfg_r.fan_sel[2];
    ctl[0].chan_id = 1'b0;
    ctl[0].last    = !sep;
    ctl[1].active  = !skip && sep;
    ctl[1].fan     = cfg_r.fan_sel[1];
    ctl[1].chan_id = 1'b1;
    ctl[1].last    = 1'b1;
  end

  for (genvar g = 0; g < 2; g++) begin : g_chan
    tfz_chan #(
      .TEMP_WIDTH    (TEMP_WIDTH),
      .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_chan (
      .ctl       (ctl[g]),
      .cfg       (cfg_r),
      .meas      (meas[g]),
      .right_spd (right_c),
      .left_spd  (left_c),
      .temp_r    (temp_r[g]),
      .prev_r    (prev_r[g]),
      .spd_r     (spd_r[g]),
      .ho_r      (ho_r[g]),
      .temp_nxt  (temp_nxt[g]),
      .prev_nxt  (prev_nxt[g]),
      .spd_nxt   (spd_nxt[g]),
      .ho_nxt    (ho_nxt[g]),
      .res       (res[g])
    );
  end

  tfz_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && !skip),
    .two       (sep),
    .res0      (res[0]),
    .res1      (res[1]),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_channel        = out_res.channel;
  assign out_cmd_valid      = out_res.cmd_valid;
  assign out_cmd_target     = out_res.cmd_target;
  assign out_cmd_speed      = out_res.cmd_speed;
  assign out_holdoff_active = out_res.holdoff_active;
  assign out_last           = out_res.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_PERIOD:   cfg_r.sample_period   <= cfg_data[5:0];
        CFG_READBACK_PERIOD: cfg_r.readback_period <= cfg_data[5:0];
        CFG_JUMP_HOLD:       cfg_r.jump_hold       <= cfg_data[5:0];
        CFG_JUMP_DELTA:      cfg_r.jump_delta      <= cfg_data[7:0];
        CFG_ZONE_THRESH:     cfg_r.thresholds      <= cfg_data[23:0];
        CFG_ZONE_SPEEDS:     cfg_r.speeds          <= cfg_data[5:0];
        CFG_MODE_BITS:       cfg_r.mode            <= cfg_data[4:0];
        CFG_FAN_SELECT:      cfg_r.fan_sel         <= cfg_data[2:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cpu_r   <= in_cpu_temp;
      gpu_r   <= in_gpu_temp;
      right_r <= in_right_fan_speed;
      left_r  <= in_left_fan_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      sc_r     <= '0;
      rc_r     <= '0;
      primed_r <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        temp_r[c] <= '0;
        prev_r[c] <= '0;
        spd_r[c]  <= SPD_STATE_RESET;
        ho_r[c]   <= '0;
      end
    end else begin
      in_vld_r <= in_vld_nxt;
      if (adv) begin
        sc_r     <= sc_nxt;
        rc_r     <= rc_nxt;
        primed_r <= primed_nxt;
        for (int c = 0; c < 2; c++) begin
          temp_r[c] <= temp_nxt[c];
          prev_r[c] <= prev_nxt[c];
          spd_r[c]  <= spd_nxt[c];
          ho_r[c]   <= ho_nxt[c];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tfz_chan.sv =====
// Per-channel readback, sample, jump holdoff, zone rule and command decision.
`default_nettype none

module tfz_chan import tfz_pkg::*; #(
  parameter int TEMP_WIDTH    = TEMP_W_DEF,
  parameter int COUNTER_WIDTH = CNT_W_DEF
) (
  input  chan_ctl_t                ctl,
  input  cfg_t                     cfg,
  input  logic [TEMP_WIDTH-1:0]    meas,
  input  spd_t                     right_spd,
  input  spd_t                     left_spd,
  input  logic [TEMP_WIDTH-1:0]    temp_r,
  input  logic [TEMP_WIDTH-1:0]    prev_r,
  input  spd_state_t               spd_r,
  input  logic [COUNTER_WIDTH-1:0] ho_r,
  output logic [TEMP_WIDTH-1:0]    temp_nxt,
  output logic [TEMP_WIDTH-1:0]    prev_nxt,
  output spd_state_t               spd_nxt,
  output logic [COUNTER_WIDTH-1:0] ho_nxt,
  output res_t                     res
);

  localparam int CMP_W = (TEMP_WIDTH > 8) ? TEMP_WIDTH : 8;

  logic [COUNTER_WIDTH-1:0] ho_dec;
  logic [TEMP_WIDTH-1:0]    temp_p;
  logic [CMP_W-1:0]         t_x;
  logic [CMP_W-1:0]         rise;
  logic [CMP_W-1:0]         t_low;
  logic [CMP_W-1:0]         t_mid;
  logic [CMP_W-1:0]         t_high;
  spd_t                     f_low;
  spd_t                     f_mid;
  spd_t                     f_high;
  logic                     jump;
  logic                     issue;
  spd_t                     cmd;
  spd_t                     obs;
  spd_t                     ls;

  assign t_x    = CMP_W'(meas);
  assign rise   = CMP_W'(meas - temp_p);
  assign t_low  = CMP_W'(cfg.thresholds[7:0]);
  assign t_mid  = CMP_W'(cfg.thresholds[15:8]);
  assign t_high = CMP_W'(cfg.thresholds[23:16]);
  assign f_low  = clamp_spd(cfg.speeds[1:0]);
  assign f_mid  = clamp_spd(cfg.speeds[3:2]);
  assign f_high = clamp_spd(cfg.speeds[5:4]);
  assign jump   = (meas > temp_p) && (rise > CMP_W'(cfg.jump_delta));

  always_comb begin
    ho_dec   = (ho_r != '0) ? ho_r - 1'b1 : ho_r;
    temp_p   = ctl.prime ? meas : temp_r;
    temp_nxt = temp_p;
    prev_nxt = ctl.prime ? meas : prev_r;
    ho_nxt   = ho_dec;
    cmd      = spd_r.cmd;
    obs      = spd_r.obs;
    ls       = spd_r.ls;

    if (ctl.active && ctl.do_rb) begin
      obs = ctl.rb_off ? cmd : (ctl.fan ? left_spd : right_spd);
      if (obs == ls) begin
        ls = SPD_NONE;
      end
    end

    if (ctl.active && ctl.do_smp) begin
      ls = SPD_NONE;
      if (ho_dec == '0) begin
        prev_nxt = temp_p;
        temp_nxt = meas;
        if (jump && !ctl.mon) begin
          ho_nxt = COUNTER_WIDTH'(cfg.jump_hold);
        end else if (ctl.boundary) begin
          priority if (t_x <= t_low && obs > f_low) begin
            cmd = f_low;
          end else if (t_x >= t_high && obs < f_high) begin
            cmd = f_high;
          end else begin
            cmd = obs;
          end
        end else begin
          priority if (t_x <= t_low) begin
            cmd = f_low;
          end else if (t_x > t_high) begin
            cmd = f_high;
          end else if (t_x >= t_mid && cmd < f_mid) begin
            cmd = f_mid;
          end else begin
            cmd = spd_r.cmd;
          end
        end
      end
    end

    issue = ctl.active && (cmd != ls) && (cmd != obs) && !ctl.mon;
    if (issue) begin
      ls = cmd;
    end

    spd_nxt = '{cmd: cmd, obs: obs, ls: ls};

    res.channel        = ctl.chan_id;
    res.cmd_valid      = issue;
    res.cmd_target     = issue ? (ctl.sep ? {1'b0, ctl.fan} : TGT_BOTH) : 2'd0;
    res.cmd_speed      = issue ? cmd : SPD_OFF;
    res.holdoff_active = (ho_nxt != '0);
    res.last           = ctl.last;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tfz_outq.sv =====
// Two-entry result buffer that releases one result beat per cycle while out_ready is high.
`default_nettype none

module tfz_outq import tfz_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic two,
  input  res_t res0,
  input  res_t res1,
  output logic free,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  res_t       r0_r;
  res_t       r1_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign free      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_res   = (cnt_r == 2'd2) ? r0_r : r1_r;

  always_comb begin
    cnt_nxt = pop ? cnt_r - 2'd1 : cnt_r;
    if (push) begin
      cnt_nxt = two ? 2'd2 : 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      r0_r <= res0;
      r1_r <= two ? res1 : res0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tfz_checker.sv =====
// Port-level checks for the thermal fan zone controller, bound to the top level.
`default_nettype none

module tfz_checker import tfz_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_channel,
  input wire logic       out_cmd_valid,
  input wire logic [1:0] out_cmd_target,
  input wire logic [1:0] out_cmd_speed,
  input wire logic       out_holdoff_active,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) &&
      $stable(out_cmd_valid) && $stable(out_cmd_target) &&
      $stable(out_cmd_speed) && $stable(out_holdoff_active) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cmd_valid |-> out_cmd_target == 2'd0 && out_cmd_speed == SPD_OFF)
    else $error("idle result carries a target or speed");

  a_gpu_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_channel |-> out_last && out_cmd_target != TGT_BOTH)
    else $error("gpu channel beat not last or addressed to both fans");

  a_cmd_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_valid |-> out_cmd_speed != SPD_NONE && out_cmd_target != 2'd3)
    else $error("command with illegal speed or target");

endmodule

bind thermal_fan_zone_controller_core tfz_checker u_tfz_checker (.*);

`default_nettype wire

// ===== dv/thermal_fan_zone_controller_core_test.sv =====
// Self-checking testbench for the fan zone controller core: predicted zone beats vs. result port.
`timescale 1ns / 1ps

module thermal_fan_zone_controller_core_test;
  import tfz_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_TICKS = 750;
  localparam int PROBE_ROWS = 24;

  typedef struct packed {
    logic [7:0] cpu;
    logic [7:0] gpu;
    logic [1:0] right;
    logic [1:0] left;
  } tick_t;

  typedef struct packed {
    logic [2:0] setting;
    tick_t      t;
    logic       typed;
    res_t       beat;
  } probe_t;

  localparam res_t QUIET_LAST = '{channel: 1'b0, cmd_valid: 1'b0, cmd_target: 2'd0,
                                  cmd_speed: SPD_OFF, holdoff_active: 1'b0, last: 1'b1};
  localparam res_t NO_BEAT = '0;

  // sample, readback, hold, delta, thresholds, speeds, mode, fan select
  localparam cfg_t PROBE_SETTINGS [5] = '{
    '{6'd1, 6'd1,  6'd3,  8'd5,   24'h503C2D, 6'd36, 5'd2,  3'd6},
    '{6'd1, 6'd1,  6'd1,  8'd255, 24'h000000, 6'd63, 5'd1,  3'd0},
    '{6'd1, 6'd1,  6'd2,  8'd0,   24'h503C2D, 6'd36, 5'd4,  3'd2},
    '{6'd2, 6'd63, 6'd63, 8'd8,   24'hFF8000, 6'd63, 5'd5,  3'd1},
    '{6'd1, 6'd1,  6'd1,  8'd0,   24'hFFFFFF, 6'd27, 5'd30, 3'd7}
  };

  localparam probe_t PROBES [PROBE_ROWS] = '{
    '{3'd0, '{8'd30,  8'd20,  2'd2, 2'd0}, 1'b1, QUIET_LAST},
    '{3'd0, '{8'd0,   8'd0,   2'd0, 2'd0}, 1'b1, QUIET_LAST},
    '{3'd0, '{8'd3,   8'd5,   2'd0, 2'd0}, 1'b0, NO_BEAT},
    '{3'd0, '{8'd5,   8'd70,  2'd0, 2'd0}, 1'b0, NO_BEAT},
    '{3'd0, '{8'd70,  8'd70,  2'd1, 2'd0}, 1'b0, NO_BEAT},
    '{3'd0, '{8'd70,  8'd70,  2'd0, 2'd0}, 1'b0, NO_BEAT},
    '{3'd0, '{8'd70,  8'd70,  2'd0, 2'd0}, 1'b0, NO_BEAT},
    '{3'd0, '{8'd70,  8'd70,  2'd2, 2'd0}, 1'b0, NO_BEAT},
    '{3'd0, '{8'd70,  8'd71,  2'd0, 2'd1}, 1'b0, NO_BEAT},
    '{3'd0, '{8'd81,  8'd60,  2'd1, 2'd3}, 1'b0, NO_BEAT},
    '{3'd1, '{8'd255, 8'd0,   2'd3, 2'd3}, 1'b0, NO_BEAT},
    '{3'd1, '{8'd0,   8'd255, 2'd0, 2'd0}, 1'b0, NO_BEAT},
    '{3'd1, '{8'd255, 8'd255, 2'd1, 2'd2}, 1'b0, NO_BEAT},
    '{3'd2, '{8'd40,  8'd90,  2'd0, 2'd0}, 1'b0, NO_BEAT},
    '{3'd2, '{8'd40,  8'd90,  2'd0, 2'd0}, 1'b0, NO_BEAT},
    '{3'd2, '{8'd50,  8'd95,  2'd2, 2'd1}, 1'b0, NO_BEAT},
    '{3'd2, '{8'd62,  8'd100, 2'd0, 2'd2}, 1'b0, NO_BEAT},
    '{3'd2, '{8'd62,  8'd40,  2'd1, 2'd1}, 1'b0, NO_BEAT},
    '{3'd3, '{8'd0,   8'd255, 2'd3, 2'd3}, 1'b0, NO_BEAT},
    '{3'd3, '{8'd255, 8'd0,   2'd0, 2'd0}, 1'b0, NO_BEAT},
    '{3'd3, '{8'd128, 8'd128, 2'd2, 2'd1}, 1'b0, NO_BEAT},
    '{3'd4, '{8'd200, 8'd10,  2'd2, 2'd2}, 1'b0, NO_BEAT},
    '{3'd4, '{8'd10,  8'd200, 2'd0, 2'd1}, 1'b0, NO_BEAT},
    '{3'd4, '{8'd255, 8'd255, 2'd3, 2'd0}, 1'b0, NO_BEAT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_cpu_temp = '0;
  logic [7:0]            in_gpu_temp = '0;
  logic [1:0]            in_right_fan_speed = '0;
  logic [1:0]            in_left_fan_speed = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_channel;
  logic                  out_cmd_valid;
  logic [1:0]            out_cmd_target;
  logic [1:0]            out_cmd_speed;
  logic                  out_holdoff_active;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted controller state
  cfg_t       zone_cfg = CFG_RESET;
  logic [7:0] zone_temp [2] = '{8'd0, 8'd0};
  logic [7:0] zone_prev [2] = '{8'd0, 8'd0};
  spd_t       fan_cmd [2] = '{SPD_OFF, SPD_OFF};
  spd_t       fan_seen [2] = '{SPD_OFF, SPD_OFF};
  spd_t       fan_sent [2] = '{SPD_NONE, SPD_NONE};
  logic [5:0] hold_left [2] = '{6'd0, 6'd0};
  logic [5:0] sample_wait = '0;
  logic [5:0] readback_wait = '0;
  logic       primed = 1'b0;

  res_t awaited_fan_beats [$];
  res_t want;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   burst_left = 0;
  bit   steady = 1'b0;
  logic rx_hold_ask = 1'b0;
  bit   rx_hold_done = 1'b0;
  int   rx_hold_left = 0;
  int   rx_run = 0;
  bit   rx_open = 1'b0;

  thermal_fan_zone_controller_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cpu_temp        (in_cpu_temp),
    .in_gpu_temp        (in_gpu_temp),
    .in_right_fan_speed (in_right_fan_speed),
    .in_left_fan_speed  (in_left_fan_speed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel        (out_channel),
    .out_cmd_valid      (out_cmd_valid),
    .out_cmd_target     (out_cmd_target),
    .out_cmd_speed      (out_cmd_speed),
    .out_holdoff_active (out_holdoff_active),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic spd_t fold_speed(input logic [1:0] s);
    return s[1] ? SPD_HIGH : s;
  endfunction

  function automatic logic [7:0] zone_reading(input int ch, input tick_t t);
    case (zone_cfg.mode[2:1])
      SRC_MAX: return (t.cpu > t.gpu) ? t.cpu : t.gpu;
      SRC_SEP: return (ch != 0) ? t.gpu : t.cpu;
      default: return t.cpu;
    endcase
  endfunction

  function automatic logic fan_of_zone(input int ch);
    if (zone_cfg.mode[2:1] == SRC_SEP) begin
      return (ch != 0) ? zone_cfg.fan_sel[1] : zone_cfg.fan_sel[0];
    end
    return zone_cfg.fan_sel[2];
  endfunction

  function automatic int predict_fan_beats(input tick_t t);
    logic       mon;
    logic       rb_off;
    logic       boundary;
    int         nch;
    spd_t       right;
    spd_t       left;
    spd_t       f_lo;
    spd_t       f_mid;
    spd_t       f_hi;
    logic [7:0] t_lo;
    logic [7:0] t_mid;
    logic [7:0] t_hi;
    logic [7:0] reading;
    spd_t       seen;
    res_t       beat;
    mon = zone_cfg.mode[MODE_MON];
    rb_off = zone_cfg.mode[MODE_RBOFF];
    boundary = zone_cfg.mode[MODE_BOUNDARY];
    right = fold_speed(t.right);
    left = fold_speed(t.left);
    t_lo = zone_cfg.thresholds[7:0];
    t_mid = zone_cfg.thresholds[15:8];
    t_hi = zone_cfg.thresholds[23:16];
    f_lo = fold_speed(zone_cfg.speeds[1:0]);
    f_mid = fold_speed(zone_cfg.speeds[3:2]);
    f_hi = fold_speed(zone_cfg.speeds[5:4]);
    if (sample_wait != 0) sample_wait = sample_wait - 6'd1;
    if (readback_wait != 0) readback_wait = readback_wait - 6'd1;
    for (int ch = 0; ch < 2; ch++) begin
      if (hold_left[ch] != 0) hold_left[ch] = hold_left[ch] - 6'd1;
    end
    if (sample_wait != 0 && (readback_wait != 0 || mon)) return 0;
    nch = (zone_cfg.mode[2:1] == SRC_SEP) ? 2 : 1;
    if (readback_wait == 0) begin
      readback_wait = rb_off ? zone_cfg.sample_period : zone_cfg.readback_period;
      for (int ch = 0; ch < nch; ch++) begin
        fan_seen[ch] = rb_off ? fan_cmd[ch] : (fan_of_zone(ch) ? left : right);
        if (fan_seen[ch] == fan_sent[ch]) fan_sent[ch] = SPD_NONE;
      end
    end
    if (sample_wait == 0) begin
      sample_wait = zone_cfg.sample_period;
      if (!primed) begin
        zone_temp[0] = zone_reading(0, t);
        zone_temp[1] = t.gpu;
        zone_prev = zone_temp;
        primed = 1'b1;
      end
      for (int ch = 0; ch < nch; ch++) begin
        fan_sent[ch] = SPD_NONE;
        if (hold_left[ch] == 0) begin
          zone_prev[ch] = zone_temp[ch];
          reading = zone_reading(ch, t);
          zone_temp[ch] = reading;
          seen = fan_seen[ch];
          if (({1'b0, reading} > {1'b0, zone_prev[ch]} + {1'b0, zone_cfg.jump_delta})
              && !mon) begin
            hold_left[ch] = zone_cfg.jump_hold;
          end else if (boundary) begin
            if (reading <= t_lo && seen > f_lo) fan_cmd[ch] = f_lo;
            else if (reading >= t_hi && seen < f_hi) fan_cmd[ch] = f_hi;
            else fan_cmd[ch] = seen;
          end else begin
            if (reading <= t_lo) fan_cmd[ch] = f_lo;
            else if (reading > t_hi) fan_cmd[ch] = f_hi;
            else if (reading >= t_mid && fan_cmd[ch] < f_mid) fan_cmd[ch] = f_mid;
          end
        end
      end
    end
    for (int ch = 0; ch < nch; ch++) begin
      beat = '0;
      beat.channel = 1'(ch);
      beat.cmd_valid = (fan_cmd[ch] != fan_sent[ch]) && (fan_cmd[ch] != fan_seen[ch]) && !mon;
      if (beat.cmd_valid) begin
        fan_sent[ch] = fan_cmd[ch];
        beat.cmd_target = (nch == 2) ? {1'b0, fan_of_zone(ch)} : TGT_BOTH;
        beat.cmd_speed = fan_cmd[ch];
      end
      beat.holdoff_active = (hold_left[ch] != 0);
      beat.last = (ch == nch - 1);
      awaited_fan_beats.push_back(beat);
    end
    return nch;
  endfunction

  function automatic logic [5:0] pick_period();
    case ($urandom_range(0, 9))
      0: return 6'd63;
      1: return 6'($urandom_range(5, 62));
      default: return 6'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic int drift(input int v);
    int n;
    if ($urandom_range(0, 24) == 0) n = int'($urandom_range(0, 255));
    else n = v + int'($urandom_range(0, 8)) - 4;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return n;
  endfunction

  task automatic send_tick(input tick_t t, output int n);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cpu_temp <= t.cpu;
    in_gpu_temp <= t.gpu;
    in_right_fan_speed <= t.right;
    in_left_fan_speed <= t.left;
    do @(posedge clk); while (!in_ready);
    n = predict_fan_beats(t);
  endtask

  // drop valid, let every awaited beat arrive, then let silent ticks leave the pipe
  task automatic drain_ticks();
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited_fan_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    logic [CFG_DATA_W-1:0] v;
    for (int i = 0; i < 8; i++) begin
      case (cfg_idx_t'(i))
        CFG_SAMPLE_PERIOD:   v = CFG_DATA_W'(s.sample_period);
        CFG_READBACK_PERIOD: v = CFG_DATA_W'(s.readback_period);
        CFG_JUMP_HOLD:       v = CFG_DATA_W'(s.jump_hold);
        CFG_JUMP_DELTA:      v = CFG_DATA_W'(s.jump_delta);
        CFG_ZONE_THRESH:     v = s.thresholds;
        CFG_ZONE_SPEEDS:     v = CFG_DATA_W'(s.speeds);
        CFG_MODE_BITS:       v = CFG_DATA_W'(s.mode);
        default:             v = CFG_DATA_W'(s.fan_sel);
      endcase
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= v;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    zone_cfg = s;
  endtask

  always @(posedge clk) begin
    if (rx_hold_ask && !rx_hold_done) begin
      rx_hold_left = 150;
      rx_hold_done = 1'b1;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_open = !rx_open;
        rx_run = rx_open ? $urandom_range(1, 16) : $urandom_range(1, 5);
      end
      rx_run--;
      out_ready <= rx_open;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_fan_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("cycle %0d: beat with none awaited: ch %0d cv %0b tgt %0d spd %0d ho %0b last %0b",
                   cycle_count, out_channel, out_cmd_valid, out_cmd_target, out_cmd_speed,
                   out_holdoff_active, out_last);
        end
      end else begin
        want = awaited_fan_beats.pop_front();
        if (out_channel !== want.channel || out_cmd_valid !== want.cmd_valid ||
            out_cmd_target !== want.cmd_target || out_cmd_speed !== want.cmd_speed ||
            out_holdoff_active !== want.holdoff_active || out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("cycle %0d: expected ch %0d cv %0b tgt %0d spd %0d ho %0b last %0b",
                     cycle_count, want.channel, want.cmd_valid, want.cmd_target,
                     want.cmd_speed, want.holdoff_active, want.last);
            $display("cycle %0d: actual   ch %0d cv %0b tgt %0d spd %0d ho %0b last %0b",
                     cycle_count, out_channel, out_cmd_valid, out_cmd_target, out_cmd_speed,
                     out_holdoff_active, out_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    tick_t      t;
    cfg_t       s;
    int         n;
    int         phase;
    int         made;
    int         walk_cpu;
    int         walk_gpu;
    logic [7:0] lo;
    logic [7:0] mid;
    logic [7:0] hi;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PROBE_ROWS; r++) begin
      if (r == 0 || PROBES[r].setting != PROBES[r-1].setting) begin
        drain_ticks();
        load_settings(PROBE_SETTINGS[PROBES[r].setting]);
        steady = ($urandom_range(0, 1) == 0);
      end
      send_tick(PROBES[r].t, n);
      if (PROBES[r].typed) begin
        if (n != 0) void'(awaited_fan_beats.pop_back());
        awaited_fan_beats.push_back(PROBES[r].beat);
      end
    end

    made = 0;
    phase = 0;
    walk_cpu = 40;
    walk_gpu = 55;
    while (made < RANDOM_TICKS) begin
      drain_ticks();
      s.sample_period = pick_period();
      s.readback_period = pick_period();
      s.jump_hold = ($urandom_range(0, 4) == 0) ? 6'd63 : 6'($urandom_range(1, 12));
      case ($urandom_range(0, 7))
        0: s.jump_delta = 8'd0;
        1: s.jump_delta = 8'd255;
        default: s.jump_delta = 8'($urandom_range(2, 20));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        s.thresholds = 24'($urandom);
      end else begin
        lo = 8'($urandom_range(10, 90));
        mid = lo + 8'($urandom_range(0, 50));
        hi = mid + 8'($urandom_range(0, 60));
        s.thresholds = {hi, mid, lo};
      end
      s.speeds = 6'($urandom_range(0, 63));
      s.mode = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 2) != 0) s.mode[MODE_MON] = 1'b0;
      s.fan_sel = 3'($urandom_range(0, 7));
      steady = ($urandom_range(0, 3) == 0);
      // hold the result port long enough for the input side to back up
      if (phase == 2) begin
        s.sample_period = 6'd1;
        steady = 1'b1;
        rx_hold_ask <= 1'b1;
      end
      load_settings(s);
      repeat ($urandom_range(30, 70)) begin
        walk_cpu = drift(walk_cpu);
        walk_gpu = drift(walk_gpu);
        t.cpu = 8'(walk_cpu);
        t.gpu = 8'(walk_gpu);
        if ($urandom_range(0, 9) < 7) begin
          t.right = fan_cmd[1'($urandom_range(0, 1))];
          t.left = fan_cmd[1'($urandom_range(0, 1))];
        end else begin
          t.right = 2'($urandom_range(0, 3));
          t.left = 2'($urandom_range(0, 3));
        end
        send_tick(t, n);
        made++;
      end
      phase++;
    end

    drain_ticks();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tfz_pkg.sv
rtl/core/tfz_chan.sv
rtl/core/tfz_outq.sv
rtl/core/thermal_fan_zone_controller_core.sv
rtl/core/tfz_checker.sv
dv/thermal_fan_zone_controller_core_test.sv
